[rtl/chunk_nesting_checker_defines.svh]
// assertion macros for the chunk nesting checker rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef CHUNK_NESTING_CHECKER_DEFINES_SVH
`define CHUNK_NESTING_CHECKER_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define CNC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that must hold in the cycle after its trigger
`define CNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cnc_pkg.sv]
// shared constants and types of the chunk nesting checker
// no dependencies; used by cnc_cell and chunk_nesting_checker
`default_nettype none

package cnc_pkg;

	localparam int MAX_LEVELS = 4;
	localparam int OFS_W      = 32;
	localparam int LVL_W      = 3;
	localparam int MASK_W     = 5;
	localparam int CONT_STEP  = 8;
	localparam int IN_W       = 2 * OFS_W;
	localparam int OUT_W      = LVL_W + 3 + 2 * MASK_W;

	localparam logic [OFS_W-1:0]        OFS_ONES = {OFS_W{1'b1}};
	localparam logic signed [OFS_W:0]   HI_EOF   = {1'b0, {OFS_W{1'b1}}};
	localparam logic signed [OFS_W:0]   ONE_H    = (OFS_W+1)'(1);
	localparam logic signed [OFS_W+1:0] ONE_X    = (OFS_W+2)'(1);
	localparam logic [OFS_W:0]          CONT_X   = (OFS_W+1)'(CONT_STEP);
	localparam logic [LVL_W-1:0]        TOP_LVL  = LVL_W'(MAX_LEVELS);

	// query token walking down the row of level cells
	typedef struct packed {
		logic                    vld;
		logic                    skip;
		logic                    cont;
		logic                    last;
		logic [LVL_W-1:0]        prev;
		logic [LVL_W-1:0]        fidx;
		logic [MASK_W-1:0]       gap;
		logic [MASK_W-1:0]       ovl;
		logic [OFS_W-1:0]        lo;
		logic signed [OFS_W:0]   hi;
	} qry_t;

	// level update broadcast to all cells
	typedef struct packed {
		logic                    en;
		logic                    clr;
		logic [LVL_W-1:0]        lev;
		logic [OFS_W-1:0]        lo;
		logic signed [OFS_W:0]   hi;
	} wr_t;

endpackage

`default_nettype wire

[rtl/cnc_cell.sv]
// one nesting level: holds the limits of the innermost chunk at that level
// depends on cnc_pkg
`default_nettype none

module cnc_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [cnc_pkg::LVL_W-1:0] idx,
	input  wire logic                      adv,
	input  wire cnc_pkg::qry_t             qry_in,
	input  wire cnc_pkg::wr_t              wr,
	output cnc_pkg::qry_t                  qry_out
);
	import cnc_pkg::*;

	logic [OFS_W-1:0]        ls_q;
	logic signed [OFS_W:0]   le_q;
	qry_t                    qry_q;
	qry_t                    qry_nxt;
	logic                    in_rng;
	logic                    chk;
	logic                    hit;
	logic                    chk_mask;
	logic signed [OFS_W+1:0] lo_x;
	logic signed [OFS_W+1:0] lo_m1;
	logic signed [OFS_W+1:0] le_x;

	always_comb begin
		in_rng = qry_in.prev >= idx;
		chk    = qry_in.vld && !qry_in.skip && in_rng && (qry_in.fidx == '0);
		hit    = !qry_in.last && (qry_in.lo >= ls_q) && (qry_in.hi <= le_q);
		// deepest level still gets a mask bit when it is overwritten
		chk_mask = chk && ((idx == TOP_LVL) || !hit) && (qry_in.lo != OFS_ONES);
		lo_x  = {2'b00, qry_in.lo};
		lo_m1 = lo_x - ONE_X;
		le_x  = {le_q[OFS_W], le_q};
		qry_nxt = qry_in;
		if (chk && hit) begin
			qry_nxt.fidx = idx;
		end
		if (chk_mask) begin
			if (le_x < lo_m1) begin
				qry_nxt.gap[idx] = 1'b1;
			end else if (le_x >= lo_x) begin
				qry_nxt.ovl[idx] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_q <= '0;
		end else if (adv) begin
			qry_q <= qry_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q <= '0;
			le_q <= '0;
		end else if (wr.clr) begin
			ls_q <= '0;
			le_q <= '0;
		end else if (wr.en && (wr.lev == idx)) begin
			ls_q <= wr.lo;
			le_q <= wr.hi;
		end
	end

	assign qry_out = qry_q;

endmodule

`default_nettype wire

[rtl/chunk_nesting_checker.sv]
// top level of the chunk nesting checker: input stage, row of level cells, result stage
// depends on cnc_pkg, cnc_cell and chunk_nesting_checker_defines.svh
//
// usage:
//   s_* channel takes one transaction per chunk record (s_tuser = 0) or one
//   end-of-list transaction (s_tuser = 1); m_* gives one result per input
//   cfg_* writes file_size (all ones = size unknown), only while idle
// timing:
//   a query token enters the cell of the deepest level in the cycle after the
//   input transaction and steps one cell per cycle down to level 1; the
//   result stage then commits the level update
//   a new item is taken only once the previous one has walked through the
//   four level cells and its result has been committed
// reset:
//   all levels clear, base level spans the whole file, file_size all ones
// stall:
//   the output register holds a result while m_tready is low; the next
//   item is taken meanwhile and its token waits at the end of the row
`default_nettype none

module chunk_nesting_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [cnc_pkg::OFS_W-1:0]   cfg_data,     // file_size
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [cnc_pkg::IN_W-1:0]    s_tdata,      // chunk_start, chunk_end
	input  wire logic                        s_tuser,      // action
	// result stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [cnc_pkg::OUT_W-1:0]        m_tdata,      // level, skipped, continuation,
	                                                       // too_deep, gap_mask, overlap_mask
	output logic                             m_tlast       // at_end
);
	import cnc_pkg::*;

	`include "chunk_nesting_checker_defines.svh"

	// config and list state
	logic [OFS_W-1:0]      fsize_q;
	logic [LVL_W-1:0]      prev_lvl_q;
	logic [OFS_W-1:0]      prev_start_q;
	logic                  have_q;
	logic                  busy_q;

	// input stage
	logic                  s_acc;
	logic [OFS_W-1:0]      raw_lo;
	logic [OFS_W-1:0]      raw_hi;
	logic [OFS_W-1:0]      lo_in;
	logic signed [OFS_W:0] hi_in;
	logic signed [OFS_W:0] fs_m1;
	logic signed [OFS_W+1:0] hi_x;
	logic signed [OFS_W+1:0] lo_m1;
	logic                  skip_in;
	logic                  cont_in;
	qry_t                  tok_nxt;
	qry_t                  tok_s1;

	// cell row and result stage
	qry_t                  link [0:MAX_LEVELS];
	logic [MAX_LEVELS-1:0] tok_vld_vec;
	qry_t                  fin;
	logic                  adv;
	logic                  commit;
	logic [LVL_W-1:0]      lev;
	logic                  deep;
	wr_t                   wr;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;
	logic                  m_tlast_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign s_acc     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize_q <= OFS_ONES;
		end else if (cfg_valid && cfg_ready) begin
			fsize_q <= cfg_data;
		end
	end

	// input stage: resolve open end, empty chunk and continuation
	always_comb begin
		raw_lo = s_tdata[OFS_W-1:0];
		raw_hi = s_tdata[IN_W-1:OFS_W];
		fs_m1  = $signed({1'b0, fsize_q}) - ONE_H;
		if (s_tuser) begin
			lo_in = fsize_q;
			hi_in = HI_EOF;
		end else begin
			lo_in = raw_lo;
			if ((raw_hi == OFS_ONES) && (fsize_q != OFS_ONES)) begin
				hi_in = fs_m1;
			end else begin
				hi_in = {1'b0, raw_hi};
			end
		end
		hi_x    = {hi_in[OFS_W], hi_in};
		lo_m1   = $signed({2'b00, lo_in}) - ONE_X;
		skip_in = !s_tuser && (hi_in != HI_EOF) && (hi_x == lo_m1);
		cont_in = have_q && ({1'b0, lo_in} > ({1'b0, prev_start_q} + CONT_X));
		// fresh token, no level found and no mask bits yet
		tok_nxt      = '0;
		tok_nxt.vld  = s_acc;
		tok_nxt.skip = skip_in;
		tok_nxt.cont = cont_in;
		tok_nxt.last = s_tuser;
		tok_nxt.prev = prev_lvl_q;
		tok_nxt.lo   = lo_in;
		tok_nxt.hi   = hi_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_nxt;
		end
	end

	// row of level cells, deepest level first
	assign link[MAX_LEVELS] = tok_s1;

	for (genvar k = MAX_LEVELS; k >= 1; k--) begin : g_cell
		cnc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (LVL_W'(k)),
			.adv     (adv),
			.qry_in  (link[k]),
			.wr      (wr),
			.qry_out (link[k-1])
		);
		assign tok_vld_vec[k-1] = link[k].vld;
	end

	assign fin = link[0];

	// result stage: level choice and commit of the level update
	assign adv    = !(fin.vld && m_tvalid_q && !m_tready);
	assign commit = fin.vld && adv;

	always_comb begin
		deep = 1'b0;
		if (fin.skip) begin
			lev = '0;
		end else if (fin.last) begin
			lev = LVL_W'(1);
		end else if (fin.fidx == TOP_LVL) begin
			lev  = TOP_LVL;
			deep = 1'b1;
		end else begin
			lev = fin.fidx + LVL_W'(1);
		end
		wr.en  = commit && !fin.skip && !fin.last;
		wr.clr = commit && fin.last;
		wr.lev = lev;
		wr.lo  = fin.lo;
		wr.hi  = fin.hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lvl_q   <= '0;
			prev_start_q <= '0;
			have_q       <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (wr.clr) begin
				// end of list: back to an empty nesting
				prev_lvl_q   <= '0;
				prev_start_q <= '0;
				have_q       <= 1'b0;
			end else if (commit) begin
				if (!fin.skip) begin
					prev_lvl_q <= lev;
				end
				prev_start_q <= fin.lo;
				have_q       <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {fin.ovl, fin.gap, deep, fin.cont, fin.skip, lev};
			m_tlast_q <= fin.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// checks
	`CNC_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_vld_vec) <= 1, "more than one token in row")
	`CNC_ASSERT_NEXT(a_commit_out, commit, m_tvalid, "committed result not presented")
	`CNC_ASSERT_NOW(a_prev_range, 1'b1, prev_lvl_q <= TOP_LVL, "previous level out of range")
	`CNC_ASSERT_NEXT(a_clear, wr.clr, (prev_lvl_q == '0) && !have_q, "end item left list state")

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for chunk_nesting_checker: directed lists, then random chunk lists
// a scoreboard class predicts every result; tasks drive input and config streams
// depends on cnc_pkg and the chunk_nesting_checker rtl
`timescale 1ns / 100ps

// input action codes carried on s_tuser
localparam logic ACT_CHUNK = 1'b0;
localparam logic ACT_END   = 1'b1;

// all-ones offset: open chunk end, unknown file size
localparam logic [cnc_pkg::OFS_W-1:0] EOF32   = cnc_pkg::OFS_ONES;
localparam longint                    EOF_OFS = longint'(cnc_pkg::OFS_ONES);

// one result as seen on {m_tlast, m_tdata}, msb first
typedef struct packed {
	logic                       at_end;
	logic [cnc_pkg::MASK_W-1:0] overlap_mask;
	logic [cnc_pkg::MASK_W-1:0] gap_mask;
	logic                       too_deep;
	logic                       continuation;
	logic                       skipped;
	logic [cnc_pkg::LVL_W-1:0]  level;
} report_t;

// tracks the open chunk at each level and queues the reports it predicts
class nesting_book;
	longint  lvl_lo[cnc_pkg::MAX_LEVELS+1];
	longint  lvl_hi[cnc_pkg::MAX_LEVELS+1];
	int      prev_lvl;
	longint  prev_lo;
	bit      have_prev;
	longint  file_len;
	report_t pending[$];
	int      errors;

	function new();
		file_len = EOF_OFS;
		errors   = 0;
		clear_levels();
	endfunction

	function void clear_levels();
		for (int i = 0; i <= cnc_pkg::MAX_LEVELS; i++) begin
			lvl_lo[i] = 0;
			lvl_hi[i] = 0;
		end
		lvl_hi[0] = EOF_OFS;
		prev_lvl  = 0;
		prev_lo   = 0;
		have_prev = 1'b0;
	endfunction

	function void set_file_size(logic [cnc_pkg::OFS_W-1:0] v);
		file_len = v;
	endfunction

	// called for every accepted input transaction
	function void note_item(logic act, logic [cnc_pkg::OFS_W-1:0] lo_in,
			logic [cnc_pkg::OFS_W-1:0] hi_in);
		longint  lo, hi;
		int      found, lvl;
		report_t r;
		r = '0;
		lvl = 0;
		if (act == ACT_END) begin
			lo = file_len;
			hi = EOF_OFS;
		end else begin
			lo = lo_in;
			hi = hi_in;
			// open end is trimmed to the last offset of the known file, -1 for an empty file
			if (hi == EOF_OFS && file_len != EOF_OFS)
				hi = file_len - 1;
		end
		r.at_end = (act == ACT_END);
		r.continuation = have_prev && (lo - cnc_pkg::CONT_STEP > prev_lo);
		r.skipped = (act == ACT_CHUNK) && hi != EOF_OFS && hi == lo - 1;
		if (!r.skipped) begin
			if (act == ACT_END) begin
				lvl = 1;
			end else begin
				found = (prev_lvl > cnc_pkg::MAX_LEVELS) ? cnc_pkg::MAX_LEVELS : prev_lvl;
				while (found > 0 && !(lo >= lvl_lo[found] && hi <= lvl_hi[found]))
					found--;
				if (found < cnc_pkg::MAX_LEVELS) begin
					lvl = found + 1;
				end else begin
					lvl = cnc_pkg::MAX_LEVELS;
					r.too_deep = 1'b1;
				end
			end
			// compare the start with every level being closed
			if (lo != EOF_OFS) begin
				for (int i = prev_lvl; i >= lvl; i--) begin
					if (lvl_hi[i] < lo - 1)
						r.gap_mask[i] = 1'b1;
					else if (lvl_hi[i] >= lo)
						r.overlap_mask[i] = 1'b1;
				end
			end
			lvl_lo[lvl] = lo;
			lvl_hi[lvl] = hi;
			prev_lvl = lvl;
		end
		r.level = lvl[cnc_pkg::LVL_W-1:0];
		if (act == ACT_END) begin
			clear_levels();
		end else begin
			prev_lo   = lo;
			have_prev = 1'b1;
		end
		pending.push_back(r);
	endfunction

	// called for every accepted result transaction
	function void check_report(report_t seen);
		report_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result %h with nothing outstanding", seen);
			return;
		end
		want = pending.pop_front();
		if (seen.level !== want.level || seen.skipped !== want.skipped ||
				seen.continuation !== want.continuation || seen.too_deep !== want.too_deep ||
				seen.gap_mask !== want.gap_mask || seen.overlap_mask !== want.overlap_mask ||
				seen.at_end !== want.at_end) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch want: lvl %0d skip %0d cont %0d deep %0d gap %b ovl %b end %0d",
					want.level, want.skipped, want.continuation, want.too_deep,
					want.gap_mask, want.overlap_mask, want.at_end);
				$display("         got:  lvl %0d skip %0d cont %0d deep %0d gap %b ovl %b end %0d",
					seen.level, seen.skipped, seen.continuation, seen.too_deep,
					seen.gap_mask, seen.overlap_mask, seen.at_end);
			end
		end
	endfunction
endclass

module testbench;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cnc_pkg::OFS_W-1:0]     cfg_data;      // file_size
	logic                          s_tvalid;
	logic                          s_tready;
	logic [cnc_pkg::IN_W-1:0]      s_tdata;       // chunk_start, chunk_end
	logic                          s_tuser;       // action
	logic                          m_tvalid;
	logic                          m_tready;
	logic [cnc_pkg::OUT_W-1:0]     m_tdata;       // level, skipped, continuation,
	                                              // too_deep, gap_mask, overlap_mask
	logic                          m_tlast;       // at_end

	nesting_book book;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          feed_burst   = 0;   // remaining back-to-back transactions, sender side
	int          sink_burst   = 0;   // same for the receiver side

	chunk_nesting_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// idle gap before the next transaction: random, with runs of back-to-back transactions
	function automatic int draw_idle(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(30, 80);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// saturate a model offset into the 32-bit field
	function automatic logic [cnc_pkg::OFS_W-1:0] ofs32(longint v);
		if (v < 0)
			return '0;
		if (v > EOF_OFS)
			return EOF32;
		return v[cnc_pkg::OFS_W-1:0];
	endfunction

	// one input transaction; entered and left at a falling edge, valid stays up
	task automatic send_item(input logic act, input logic [cnc_pkg::OFS_W-1:0] lo,
			input logic [cnc_pkg::OFS_W-1:0] hi);
		int idle;
		idle = draw_idle(feed_burst);
		if (idle > 0) begin
			s_tvalid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {hi, lo};
		do @(posedge clk); while (!s_tready);
		book.note_item(act, lo, hi);
		items_sent++;
		@(negedge clk);
	endtask

	// file_size write, only once every outstanding result has come back
	task automatic write_file_size(input logic [cnc_pkg::OFS_W-1:0] v);
		s_tvalid = 1'b0;
		while (book.pending.size() != 0)
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		book.set_file_size(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one chunk list in file order: nested and sibling chunks with random lengths,
	// sprinkled with empty chunks, open ends, shifted starts and junk records
	task automatic send_chunk_list(input logic [cnc_pkg::OFS_W-1:0] fs);
		longint open_ends[$];
		longint span, pos, lo, hi, room;
		int     count, kind;
		span = (fs == EOF32) ? longint'($urandom_range(256, 50000)) : longint'(fs);
		// sometimes the chunks do not quite fill the file
		if ($urandom_range(0, 2) == 0)
			span = span + longint'($urandom_range(0, 32)) - 16;
		if (span < 1)
			span = 1;
		count = $urandom_range(1, 24);
		pos = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 16)) : 0;
		open_ends.push_back(span - 1);
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind >= 96) begin
				// junk record over the full offset range
				send_item(ACT_CHUNK, $urandom, $urandom);
				continue;
			end
			// step out of finished chunks
			while (open_ends.size() > 1 && (pos > open_ends[$] || $urandom_range(0, 3) == 0))
				pos = open_ends.pop_back() + 1;
			room = open_ends[$] - pos;
			if (room < 0)
				room = $urandom_range(0, 40);
			if (room > 6000)
				room = $urandom_range(0, 6000);
			lo = pos;
			hi = lo + longint'($urandom_range(0, 32'(room)));
			if (kind < 6)
				hi = lo - 1;                     // empty chunk
			else if (kind < 12)
				hi = EOF_OFS;                    // runs to end of file
			else if (kind < 20) begin
				lo = lo + longint'($urandom_range(0, 12)) - 6;   // gap or overlap
				if (lo < 0)
					lo = 0;
			end
			send_item(ACT_CHUNK, ofs32(lo), ofs32(hi));
			if (hi == lo - 1) begin
				pos = lo;
			end else if (hi == EOF_OFS || ($urandom_range(0, 1) == 0 && open_ends.size() < 8)) begin
				// descend: children follow a short header
				open_ends.push_back(hi);
				pos = lo + longint'($urandom_range(0, 12));
			end else begin
				pos = hi + 1;
			end
		end
		// most lists are closed; a missing end lets the levels carry into the next list
		if ($urandom_range(0, 7) != 0)
			send_item(ACT_END, $urandom, $urandom);
		if ($urandom_range(0, 15) == 0)
			send_item(ACT_END, $urandom, $urandom);
	endtask

	// result side: random stalls, a few long hold-offs so the block backs up
	initial begin : result_sink
		int hold;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			hold = draw_idle(sink_burst);
			if (results_seen % 450 == 300)
				hold = 200;
			if (hold > 0) begin
				m_tready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			book.check_report({m_tlast, m_tdata});
			results_seen++;
			@(negedge clk);
		end
	end

	// stimulus
	initial begin : stimulus
		logic [cnc_pkg::OFS_W-1:0] fs;
		int                        target;
		book      = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_CHUNK;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: size unknown
		write_file_size(EOF32);
		send_item(ACT_CHUNK, 0, 99);
		send_item(ACT_CHUNK, 8, 49);
		send_item(ACT_CHUNK, 17, 29);         // start jumps by more than the step
		send_item(ACT_CHUNK, 20, 25);
		send_item(ACT_CHUNK, 21, 22);         // fifth level: too deep
		send_item(ACT_CHUNK, 23, 22);         // empty chunk
		send_item(ACT_CHUNK, 50, 99);         // closes levels with gaps
		send_item(ACT_CHUNK, 40, 60);         // overlaps the previous sibling
		send_item(ACT_CHUNK, 0, 0);
		send_item(ACT_CHUNK, EOF32, EOF32);   // start at eof: no masks
		send_item(ACT_CHUNK, 100, EOF32);     // open end, size unknown
		send_item(ACT_END, 0, 0);             // unknown size sets continuation
		send_item(ACT_END, EOF32, EOF32);     // end of an empty list
		// empty file: an open end becomes -1 and the chunk is skipped
		write_file_size('0);
		send_item(ACT_CHUNK, 0, EOF32);
		send_item(ACT_END, 0, 0);
		// known size: gap before end of file, then overrun past it
		write_file_size(200);
		send_item(ACT_CHUNK, 0, EOF32);
		send_item(ACT_CHUNK, 8, 150);
		send_item(ACT_END, 5, 7);
		send_item(ACT_CHUNK, 0, 300);
		send_item(ACT_END, EOF32, 0);

		// random lists under several file sizes, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       fs = EOF32;
				1:       fs = '0;
				2:       fs = 1;
				3:       fs = EOF32 - 1;
				4:       fs = $urandom_range(64, 4000);
				5:       fs = $urandom_range(4000, 1_000_000);
				6:       fs = $urandom;
				default: fs = $urandom_range(100, 20000);
			endcase
			write_file_size(fs);
			target = items_sent + 230;
			while (items_sent < target)
				send_chunk_list(fs);
		end

		// drain, then wait on for stray results
		s_tvalid = 1'b0;
		while (book.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (book.errors == 0 && book.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[chunk_nesting_checker.f]
+incdir+rtl
rtl/cnc_pkg.sv
rtl/cnc_cell.sv
rtl/chunk_nesting_checker.sv
tb/testbench.sv
